>>> hdl/kedpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kedpm_pkg;

	localparam int AVG_SHIFT_DEF = 4;
	localparam int KNOB_BITS_DEF = 12;

	localparam int RAW_W      = 12;
	localparam int FILT_W     = 12;
	localparam int PITCH_W    = 18;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int SETTLE_W   = 16;
	localparam int LEVEL_W    = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam int QUEUE_DEPTH = 4;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 16'd100;
	localparam logic [SETTLE_W-1:0]   SETTLE_RST    = 16'd300;
	localparam logic [LEVEL_W-1:0]    DEADBAND_RST  = 12'd24;
	localparam logic [LEVEL_W-1:0]    ZERO_SNAP_RST = 12'd82;
	localparam logic [PITCH_W-1:0]    TOP_PITCH_RST = 18'd51200;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_INTERVAL = 3'd0,
		CFG_SETTLE          = 3'd1,
		CFG_DEADBAND        = 3'd2,
		CFG_ZERO_SNAP       = 3'd3,
		CFG_TOP_FIRST       = 3'd4,
		CFG_TOP_SECOND      = 3'd5
	} cfg_idx_t;

	// classification of one item, front to back
	typedef struct packed {
		logic write_first;
		logic write_second;
		logic zero_first;
		logic zero_second;
		logic settle_report;
	} item_flags_t;

endpackage

`default_nettype wire

>>> hdl/kedpm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kedpm_front #(
	parameter int AVG_SHIFT = kedpm_pkg::AVG_SHIFT_DEF,
	parameter int KNOB_BITS = kedpm_pkg::KNOB_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  cmd,
	input  wire logic [kedpm_pkg::TIME_W-1:0]          now_ms,
	input  wire logic [kedpm_pkg::RAW_W-1:0]           raw_pot,
	input  wire logic                                  first_on,
	input  wire logic                                  second_on,
	input  wire logic [kedpm_pkg::INTERVAL_W-1:0]      sample_interval_ms,
	input  wire logic [kedpm_pkg::SETTLE_W-1:0]        settle_ms,
	input  wire logic [kedpm_pkg::LEVEL_W-1:0]         deadband,
	input  wire logic [kedpm_pkg::LEVEL_W-1:0]         zero_snap,
	input  wire logic                                  queue_full,
	output logic                                       push,
	output kedpm_pkg::item_flags_t                     push_flags,
	output logic [KNOB_BITS-1:0]                       push_level
);

	localparam int AW = KNOB_BITS + AVG_SHIFT;
	localparam int CW = (KNOB_BITS > kedpm_pkg::LEVEL_W) ? KNOB_BITS : kedpm_pkg::LEVEL_W;

	logic [kedpm_pkg::TIME_W-1:0] last_sample_q;
	logic                         have_sample_q;
	logic [AW-1:0]                acc_q;
	logic                         seeded_q;
	logic [KNOB_BITS-1:0]         ref_q;
	logic                         pending_q;
	logic [kedpm_pkg::TIME_W-1:0] last_change_q;

	logic [KNOB_BITS+kedpm_pkg::RAW_W-1:0] raw_wide;
	logic [KNOB_BITS-1:0]                  raw_k;
	logic [kedpm_pkg::TIME_W-1:0]          since_sample;
	logic [kedpm_pkg::TIME_W-1:0]          since_change;
	logic                                  too_soon;
	logic                                  take;
	logic                                  accept;
	logic [AW-1:0]                         acc_ema;
	logic [AW-1:0]                         acc_seed;
	logic [AW-1:0]                         acc_next;
	logic [KNOB_BITS-1:0]                  lvl_ema;
	logic [KNOB_BITS-1:0]                  moved;
	logic                                  moved_big;
	logic                                  settled;
	logic                                  moving;
	logic                                  at_zero;

	always_comb begin
		raw_wide     = (KNOB_BITS + kedpm_pkg::RAW_W)'(raw_pot);
		raw_k        = raw_wide[KNOB_BITS-1:0];
		since_sample = now_ms - last_sample_q;
		since_change = now_ms - last_change_q;
		too_soon     = have_sample_q &&
			(since_sample < kedpm_pkg::TIME_W'(sample_interval_ms));
		take         = (cmd == kedpm_pkg::CMD_SAMPLE) && (first_on || second_on) && !too_soon;
		accept       = in_valid && in_ready;

		acc_ema  = acc_q + AW'(raw_k) - (acc_q >> AVG_SHIFT);
		acc_seed = AW'(raw_k) << AVG_SHIFT;
		lvl_ema  = acc_ema[AW-1:AVG_SHIFT];
		moved    = (lvl_ema >= ref_q) ? (lvl_ema - ref_q) : (ref_q - lvl_ema);
		moved_big = CW'(moved) > CW'(deadband);
		settled  = pending_q && (since_change >= kedpm_pkg::TIME_W'(settle_ms));
		moving   = take && seeded_q && moved_big;
		at_zero  = CW'(lvl_ema) <= CW'(zero_snap);

		if (take) begin
			acc_next = seeded_q ? acc_ema : acc_seed;
		end else begin
			acc_next = acc_q;
		end
	end

	assign in_ready   = !queue_full;
	assign push       = accept;
	assign push_level = acc_next[AW-1:AVG_SHIFT];

	always_comb begin
		push_flags.write_first   = moving && first_on;
		push_flags.write_second  = moving && second_on;
		push_flags.zero_first    = at_zero;
		push_flags.zero_second   = at_zero;
		push_flags.settle_report = take && seeded_q && !moved_big && settled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= '0;
			have_sample_q <= 1'b0;
			acc_q         <= '0;
			seeded_q      <= 1'b0;
			ref_q         <= '0;
			pending_q     <= 1'b0;
			last_change_q <= '0;
		end else if (accept) begin
			if (cmd == kedpm_pkg::CMD_RESEED) begin
				pending_q <= 1'b0;
				seeded_q  <= 1'b0;
			end else if (take) begin
				last_sample_q <= now_ms;
				have_sample_q <= 1'b1;
				acc_q         <= acc_next;
				if (!seeded_q) begin
					seeded_q <= 1'b1;
					ref_q    <= raw_k;
				end else if (moved_big) begin
					ref_q         <= lvl_ema;
					last_change_q <= now_ms;
					pending_q     <= 1'b1;
				end else if (settled) begin
					pending_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/kedpm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module kedpm_queue #(
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] push_data,
	output logic               full,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output logic [DW-1:0]      pop_data
);

	localparam int DEPTH = kedpm_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CNTW  = $clog2(DEPTH + 1);

	logic [DW-1:0]   slot_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CNTW-1:0] count_q;
	logic            pop;

	assign full      = count_q == CNTW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/kedpm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module kedpm_back #(
	parameter int KNOB_BITS = kedpm_pkg::KNOB_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pop_valid,
	output logic                                  pop_ready,
	input  wire kedpm_pkg::item_flags_t           pop_flags,
	input  wire logic [KNOB_BITS-1:0]             pop_level,
	input  wire logic [kedpm_pkg::PITCH_W-1:0]    top_pitch_first,
	input  wire logic [kedpm_pkg::PITCH_W-1:0]    top_pitch_second,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  write_first,
	output logic                                  write_second,
	output logic [kedpm_pkg::PITCH_W-1:0]         pitch_first,
	output logic [kedpm_pkg::PITCH_W-1:0]         pitch_second,
	output logic                                  settle_report,
	output logic [kedpm_pkg::FILT_W-1:0]          filtered_level
);

	localparam int PW  = kedpm_pkg::PITCH_W;
	localparam int XW  = KNOB_BITS + PW;
	localparam int NT  = (XW + KNOB_BITS - 1) / KNOB_BITS;
	localparam int RW  = KNOB_BITS + 4;
	localparam int DIV = (1 << KNOB_BITS) - 1;

	// x / (2^K - 1) estimated as sum of x >> iK; short by at most NT
	function automatic logic [PW-1:0] est_quot(input logic [XW-1:0] x);
		logic [XW-1:0] s;
		s = '0;
		for (int i = 1; i <= NT; i++) begin
			s = s + (x >> (KNOB_BITS * i));
		end
		return s[PW-1:0];
	endfunction

	function automatic logic [RW-1:0] est_rem(input logic [XW-1:0] x,
			input logic [PW-1:0] q);
		logic [XW:0] t;
		t = {1'b0, x} - ((XW + 1)'(q) << KNOB_BITS) + (XW + 1)'(q);
		return t[RW-1:0];
	endfunction

	function automatic logic [PW-1:0] fix_quot(input logic [PW-1:0] q,
			input logic [RW-1:0] r);
		logic [PW-1:0] c;
		c = '0;
		for (int j = 1; j <= NT; j++) begin
			if (r >= RW'(j * DIV)) begin
				c = c + 1'b1;
			end
		end
		return q + c;
	endfunction

	logic                    adv;

	logic                    valid_s1;
	kedpm_pkg::item_flags_t  flags_s1;
	logic [KNOB_BITS-1:0]    level_s1;
	logic [XW-1:0]           prod_first_s1;
	logic [XW-1:0]           prod_second_s1;

	logic                    valid_s2;
	kedpm_pkg::item_flags_t  flags_s2;
	logic [KNOB_BITS-1:0]    level_s2;
	logic [PW-1:0]           quot_first_s2;
	logic [PW-1:0]           quot_second_s2;
	logic [RW-1:0]           rem_first_s2;
	logic [RW-1:0]           rem_second_s2;

	logic                    valid_s3;
	logic                    write_first_s3;
	logic                    write_second_s3;
	logic [PW-1:0]           pitch_first_s3;
	logic [PW-1:0]           pitch_second_s3;
	logic                    report_s3;
	logic [KNOB_BITS-1:0]    level_s3;

	logic [PW-1:0]           quot_first_est;
	logic [PW-1:0]           quot_second_est;
	logic [PW-1:0]           quot_first_fix;
	logic [PW-1:0]           quot_second_fix;

	assign adv       = !valid_s3 || out_ready;
	assign pop_ready = adv;

	always_comb begin
		quot_first_est  = est_quot(prod_first_s1);
		quot_second_est = est_quot(prod_second_s1);
		quot_first_fix  = fix_quot(quot_first_s2, rem_first_s2);
		quot_second_fix = fix_quot(quot_second_s2, rem_second_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1       <= pop_flags;
			level_s1       <= pop_level;
			prod_first_s1  <= XW'(pop_level) * XW'(top_pitch_first);
			prod_second_s1 <= XW'(pop_level) * XW'(top_pitch_second);

			flags_s2       <= flags_s1;
			level_s2       <= level_s1;
			quot_first_s2  <= quot_first_est;
			quot_second_s2 <= quot_second_est;
			rem_first_s2   <= est_rem(prod_first_s1, quot_first_est);
			rem_second_s2  <= est_rem(prod_second_s1, quot_second_est);

			write_first_s3  <= flags_s2.write_first;
			write_second_s3 <= flags_s2.write_second;
			pitch_first_s3  <= (flags_s2.write_first && !flags_s2.zero_first) ?
				quot_first_fix : '0;
			pitch_second_s3 <= (flags_s2.write_second && !flags_s2.zero_second) ?
				quot_second_fix : '0;
			report_s3       <= flags_s2.settle_report;
			level_s3        <= level_s2;
		end
	end

	assign out_valid      = valid_s3;
	assign write_first    = write_first_s3;
	assign write_second   = write_second_s3;
	assign pitch_first    = pitch_first_s3;
	assign pitch_second   = pitch_second_s3;
	assign settle_report  = report_s3;
	assign filtered_level = kedpm_pkg::FILT_W'(level_s3);

endmodule

`default_nettype wire

>>> hdl/knob_ema_deadband_pitch_mapper.sv
// An accepted item is written into the queue, then moves through pitch stages s1, s2 and s3 to the output.
// Throughput: one item per cycle while the queue is not full; the front updates its filter state as it accepts an item.
// A 4-entry queue lets the front keep accepting while the 3-stage pitch pipeline is stalled.
// Reset (arst_n low): config registers return to their defaults, valid and queue state clears, filter state is cleared.
`timescale 1ns / 1ps
`default_nettype none

module knob_ema_deadband_pitch_mapper #(
	parameter int AVG_SHIFT = kedpm_pkg::AVG_SHIFT_DEF,
	parameter int KNOB_BITS = kedpm_pkg::KNOB_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               cmd,
	input  wire logic [kedpm_pkg::TIME_W-1:0]       now_ms,
	input  wire logic [kedpm_pkg::RAW_W-1:0]        raw_pot,
	input  wire logic                               first_on,
	input  wire logic                               second_on,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    write_first,
	output logic                                    write_second,
	output logic [kedpm_pkg::PITCH_W-1:0]           pitch_first,
	output logic [kedpm_pkg::PITCH_W-1:0]           pitch_second,
	output logic                                    settle_report,
	output logic [kedpm_pkg::FILT_W-1:0]            filtered_level,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [kedpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [kedpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int FW = $bits(kedpm_pkg::item_flags_t);
	localparam int DW = FW + KNOB_BITS;

	logic [kedpm_pkg::INTERVAL_W-1:0] interval_q;
	logic [kedpm_pkg::SETTLE_W-1:0]   settle_q;
	logic [kedpm_pkg::LEVEL_W-1:0]    deadband_q;
	logic [kedpm_pkg::LEVEL_W-1:0]    zero_snap_q;
	logic [kedpm_pkg::PITCH_W-1:0]    top_first_q;
	logic [kedpm_pkg::PITCH_W-1:0]    top_second_q;

	logic                   queue_full;
	logic                   push;
	kedpm_pkg::item_flags_t push_flags;
	logic [KNOB_BITS-1:0]   push_level;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [DW-1:0]          pop_data;
	kedpm_pkg::item_flags_t pop_flags;
	logic [KNOB_BITS-1:0]   pop_level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q   <= kedpm_pkg::INTERVAL_RST;
			settle_q     <= kedpm_pkg::SETTLE_RST;
			deadband_q   <= kedpm_pkg::DEADBAND_RST;
			zero_snap_q  <= kedpm_pkg::ZERO_SNAP_RST;
			top_first_q  <= kedpm_pkg::TOP_PITCH_RST;
			top_second_q <= kedpm_pkg::TOP_PITCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (kedpm_pkg::cfg_idx_t'(cfg_index))
				kedpm_pkg::CFG_SAMPLE_INTERVAL: begin
					interval_q <= cfg_data[kedpm_pkg::INTERVAL_W-1:0];
				end
				kedpm_pkg::CFG_SETTLE: begin
					settle_q <= cfg_data[kedpm_pkg::SETTLE_W-1:0];
				end
				kedpm_pkg::CFG_DEADBAND: begin
					deadband_q <= cfg_data[kedpm_pkg::LEVEL_W-1:0];
				end
				kedpm_pkg::CFG_ZERO_SNAP: begin
					zero_snap_q <= cfg_data[kedpm_pkg::LEVEL_W-1:0];
				end
				kedpm_pkg::CFG_TOP_FIRST: begin
					top_first_q <= cfg_data[kedpm_pkg::PITCH_W-1:0];
				end
				kedpm_pkg::CFG_TOP_SECOND: begin
					top_second_q <= cfg_data[kedpm_pkg::PITCH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	kedpm_front #(
		.AVG_SHIFT (AVG_SHIFT),
		.KNOB_BITS (KNOB_BITS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.cmd                (cmd),
		.now_ms             (now_ms),
		.raw_pot            (raw_pot),
		.first_on           (first_on),
		.second_on          (second_on),
		.sample_interval_ms (interval_q),
		.settle_ms          (settle_q),
		.deadband           (deadband_q),
		.zero_snap          (zero_snap_q),
		.queue_full         (queue_full),
		.push               (push),
		.push_flags         (push_flags),
		.push_level         (push_level)
	);

	kedpm_queue #(
		.DW (DW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_flags, push_level}),
		.full      (queue_full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	assign pop_flags = kedpm_pkg::item_flags_t'(pop_data[DW-1:KNOB_BITS]);
	assign pop_level = pop_data[KNOB_BITS-1:0];

	kedpm_back #(
		.KNOB_BITS (KNOB_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.pop_valid        (pop_valid),
		.pop_ready        (pop_ready),
		.pop_flags        (pop_flags),
		.pop_level        (pop_level),
		.top_pitch_first  (top_first_q),
		.top_pitch_second (top_second_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.write_first      (write_first),
		.write_second     (write_second),
		.pitch_first      (pitch_first),
		.pitch_second     (pitch_second),
		.settle_report    (settle_report),
		.filtered_level   (filtered_level)
	);

endmodule

`default_nettype wire
